// ----- design/cre_pkg.sv -----
// ----------------------------------------------------------------------------
// cre_pkg
// Shared types and codes of the change report encoder.
// ----------------------------------------------------------------------------
package cre_pkg;

  localparam logic [1:0] MODE_CHANGE = 2'd0;
  localparam logic [1:0] MODE_MAX    = 2'd1;
  localparam logic [1:0] MODE_MIN    = 2'd2;
  localparam logic [1:0] MODE_CLEAR  = 2'd3;

  localparam logic [2:0] KIND_FLAG = 3'd0;
  localparam logic [2:0] KIND_BYTE = 3'd1;
  localparam logic [2:0] KIND_U16  = 3'd2;
  localparam logic [2:0] KIND_S16  = 3'd3;
  localparam logic [2:0] KIND_U32  = 3'd4;

  typedef enum logic [1:0] {
    SIZE_1,
    SIZE_2,
    SIZE_4
  } cre_size_t;

  typedef struct packed {
    logic [7:0]  code;
    logic [31:0] value;
    cre_size_t   size;
  } cre_desc_t;

endpackage

// ----- design/cre_if.sv -----
// ----------------------------------------------------------------------------
// cre channel interfaces
// Request, record byte and configuration channels with valid/ready.
// ----------------------------------------------------------------------------
interface cre_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [7:0]  point_code;
  logic [2:0]  value_kind;
  logic [31:0] point_value;

  modport source (output valid, mode, point_code, value_kind, point_value, input ready);
  modport sink (input valid, mode, point_code, value_kind, point_value, output ready);
endinterface

interface cre_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;

  modport source (output valid, out_byte, last_byte, input ready);
  modport sink (input valid, out_byte, last_byte, output ready);
endinterface

interface cre_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] start_marker;

  modport source (output valid, start_marker, input ready);
  modport sink (input valid, start_marker, output ready);
endinterface

// ----- design/change_report_encoder_core.sv -----
// A reported request passes the lookup stage, a queue slot, the record register and the
// output byte register before its first byte shows. No request is taken during a lookup;
// the serializer sends one byte per cycle while out_chan is ready; a record has 3, 4 or 6 bytes.
// Reset: synchronous; all valid bits clear at once, the marker resets to 0,
// and the value cache holds no reset value and needs no clearing pass.
// ----------------------------------------------------------------------------
// change_report_encoder_core
// Report-by-exception encoder with per-code value cache and byte output.
// ----------------------------------------------------------------------------
module change_report_encoder_core #(
  parameter int NUM_CODES = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  cre_in_if.sink    in_chan,
  cre_out_if.source out_chan,
  cre_cfg_if.sink   cfg_chan
);
  import cre_pkg::*;

  logic [7:0] start_marker_r;
  logic       push_valid;
  logic       push_ready;
  cre_desc_t  push_desc;
  logic       pop_valid;
  logic       pop_ready;
  cre_desc_t  pop_desc;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_marker_r <= 8'd0;
    end else if (cfg_chan.valid && cfg_chan.ready) begin
      start_marker_r <= cfg_chan.start_marker;
    end
  end

  cre_front #(
    .NUM_CODES(NUM_CODES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .push_valid (push_valid),
    .push_desc  (push_desc),
    .push_ready (push_ready)
  );

  cre_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_desc  (push_desc),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_desc   (pop_desc),
    .pop_ready  (pop_ready)
  );

  cre_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .start_marker (start_marker_r),
    .pop_valid    (pop_valid),
    .pop_desc     (pop_desc),
    .pop_ready    (pop_ready),
    .out_chan     (out_chan)
  );

endmodule

// ----- design/cre_front.sv -----
// ----------------------------------------------------------------------------
// cre_front
// Accepts requests, looks up the cached value and valid bit of the code, decides whether
// a record is due, updates the cache and queues the record; a clear drops all valid bits.
// ----------------------------------------------------------------------------
module cre_front #(
  parameter int NUM_CODES = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  cre_in_if.sink             in_chan,
  output logic               push_valid,
  output cre_pkg::cre_desc_t push_desc,
  input  logic               push_ready
);
  import cre_pkg::*;

  localparam int IDX_W = $clog2(NUM_CODES);

  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  state_t      state_r;
  logic [1:0]  mode_r;
  logic [7:0]  code_r;
  logic [2:0]  kind_r;
  logic [31:0] raw_r;
  logic [31:0] old_r;

  logic [31:0] cache_mem [NUM_CODES];
  logic        valid_r [NUM_CODES];

  logic             accept;
  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] idx;
  logic             in_range;
  logic [31:0]      norm;
  logic             gt_new;
  logic             gt_old;
  logic             emit;
  logic             push;
  cre_size_t        size;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;
  assign rd_idx        = in_chan.point_code[IDX_W-1:0];
  assign idx           = code_r[IDX_W-1:0];
  assign in_range      = ({1'b0, code_r} < 9'(NUM_CODES));

  always_comb begin
    case (kind_r)
      KIND_FLAG: norm = {31'd0, |raw_r};
      KIND_BYTE: norm = {24'd0, raw_r[7:0]};
      KIND_U16, KIND_S16: norm = {16'd0, raw_r[15:0]};
      default: norm = raw_r;
    endcase
  end

  always_comb begin
    if (kind_r == KIND_S16) begin
      gt_new = $signed(norm[15:0]) > $signed(old_r[15:0]);
      gt_old = $signed(old_r[15:0]) > $signed(norm[15:0]);
    end else begin
      gt_new = norm > old_r;
      gt_old = old_r > norm;
    end
  end

  always_comb begin
    if (!valid_r[idx]) begin
      emit = 1'b1;
    end else begin
      case (mode_r)
        MODE_CHANGE: emit = (old_r != norm);
        MODE_MAX:    emit = gt_new;
        default:     emit = gt_old;
      endcase
    end
    emit = emit && in_range;
  end

  always_comb begin
    if (kind_r <= KIND_BYTE) begin
      size = SIZE_1;
    end else if (kind_r <= KIND_S16) begin
      size = SIZE_2;
    end else begin
      size = SIZE_4;
    end
  end

  assign push_valid      = (state_r == ST_LOOKUP) && emit;
  assign push_desc.code  = code_r;
  assign push_desc.value = norm;
  assign push_desc.size  = size;
  assign push            = push_valid && push_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      cache_mem[idx] <= norm;
    end
    if (accept) begin
      old_r <= cache_mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CODES; i++) valid_r[i] <= 1'b0;
    end else if (accept && in_chan.mode == MODE_CLEAR) begin
      for (int i = 0; i < NUM_CODES; i++) valid_r[i] <= 1'b0;
    end else if (push) begin
      valid_r[idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            mode_r <= in_chan.mode;
            code_r <= in_chan.point_code;
            kind_r <= in_chan.value_kind;
            raw_r  <= in_chan.point_value;
            if (in_chan.mode != MODE_CLEAR) state_r <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          if (!emit || push_ready) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- design/cre_queue.sv -----
// ----------------------------------------------------------------------------
// cre_queue
// Two-entry queue of pending records between the lookup and the serializer.
// ----------------------------------------------------------------------------
module cre_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  input  cre_pkg::cre_desc_t push_desc,
  output logic               push_ready,
  output logic               pop_valid,
  output cre_pkg::cre_desc_t pop_desc,
  input  logic               pop_ready
);
  import cre_pkg::*;

  cre_desc_t  slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       push;
  logic       pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_desc   = slot_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        slot_r[wr_ptr_r] <= push_desc;
        wr_ptr_r         <= ~wr_ptr_r;
      end
      if (pop) rd_ptr_r <= ~rd_ptr_r;
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule

// ----- design/cre_back.sv -----
// ----------------------------------------------------------------------------
// cre_back
// Serializes queued records into marker, code and big-endian value bytes.
// ----------------------------------------------------------------------------
module cre_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [7:0]         start_marker,
  input  logic               pop_valid,
  input  cre_pkg::cre_desc_t pop_desc,
  output logic               pop_ready,
  cre_out_if.source          out_chan
);
  import cre_pkg::*;

  cre_desc_t  desc_r;
  logic [2:0] idx_r;
  logic       busy_r;
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;

  logic       adv;
  logic       is_last;
  logic [2:0] last_idx;
  logic [7:0] sel_byte;

  always_comb begin
    case (desc_r.size)
      SIZE_1:  last_idx = 3'd2;
      SIZE_2:  last_idx = 3'd3;
      default: last_idx = 3'd5;
    endcase
  end

  always_comb begin
    case (idx_r)
      3'd0: sel_byte = start_marker;
      3'd1: sel_byte = desc_r.code;
      3'd2: begin
        case (desc_r.size)
          SIZE_1:  sel_byte = desc_r.value[7:0];
          SIZE_2:  sel_byte = desc_r.value[15:8];
          default: sel_byte = desc_r.value[31:24];
        endcase
      end
      3'd3: sel_byte = (desc_r.size == SIZE_2) ? desc_r.value[7:0] : desc_r.value[23:16];
      3'd4: sel_byte = desc_r.value[15:8];
      default: sel_byte = desc_r.value[7:0];
    endcase
  end

  assign is_last   = (idx_r == last_idx);
  assign adv       = !out_valid_r || out_chan.ready;
  assign pop_ready = adv && (!busy_r || is_last);

  assign out_chan.valid     = out_valid_r;
  assign out_chan.out_byte  = out_byte_r;
  assign out_chan.last_byte = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= 3'd0;
    end else if (adv) begin
      if (busy_r) begin
        out_valid_r <= 1'b1;
        out_byte_r  <= sel_byte;
        out_last_r  <= is_last;
      end else begin
        out_valid_r <= 1'b0;
      end
      if (!busy_r || is_last) begin
        if (pop_valid) begin
          desc_r <= pop_desc;
          idx_r  <= 3'd0;
          busy_r <= 1'b1;
        end else begin
          busy_r <= 1'b0;
        end
      end else begin
        idx_r <= idx_r + 3'd1;
      end
    end
  end

endmodule
